[hdl/e2q_pkg.sv]
package e2q_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int NUM_STAGES        = 32;
  localparam int CW                = 34;   // CORDIC x, y, z width
  localparam int OUT_W             = 16;

  localparam logic signed [CW-1:0] GAIN_START = 34'sd652032874;

  typedef logic signed [CW-1:0] cw_t;

  // Arctangent table in half-angle units (2^32 stands for pi).
  function automatic cw_t atan_val(input int i);
    cw_t r;
    case (i)
      0: r = 34'sd1073741824;   1: r = 34'sd633866812;
      2: r = 34'sd334917814;    3: r = 34'sd170009512;
      4: r = 34'sd85334662;     5: r = 34'sd42708930;
      6: r = 34'sd21359676;     7: r = 34'sd10680490;
      8: r = 34'sd5340326;      9: r = 34'sd2670174;
      10: r = 34'sd1335088;     11: r = 34'sd667544;
      12: r = 34'sd333772;      13: r = 34'sd166886;
      14: r = 34'sd83443;       15: r = 34'sd41722;
      16: r = 34'sd20861;       17: r = 34'sd10430;
      18: r = 34'sd5215;        19: r = 34'sd2608;
      20: r = 34'sd1304;        21: r = 34'sd652;
      22: r = 34'sd326;         23: r = 34'sd163;
      24: r = 34'sd81;          25: r = 34'sd41;
      26: r = 34'sd20;          27: r = 34'sd10;
      28: r = 34'sd5;           29: r = 34'sd3;
      30: r = 34'sd1;           31: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/e2q_cordic.sv]
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic                         out_valid,
  output cw_t                          cos_out,
  output cw_t                          sin_out
);

  // One register stage per CORDIC iteration; the whole pipe advances on en.
  cw_t  x_r [NUM_STAGES+1];
  cw_t  y_r [NUM_STAGES+1];
  cw_t  z_r [NUM_STAGES+1];
  logic v_r [NUM_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_START;
      y_r[0] <= '0;
      z_r[0] <= cw_t'(angle) <<< (32 - ANGLE_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    cw_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_val(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  assign out_valid = v_r[NUM_STAGES];
  assign cos_out   = x_r[NUM_STAGES];
  assign sin_out   = y_r[NUM_STAGES];

endmodule

[hdl/e2q_product.sv]
module e2q_product
  import e2q_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  cw_t                     cy,
  input  cw_t                     sy,
  input  cw_t                     cp,
  input  cw_t                     sp,
  input  cw_t                     cr,
  input  cw_t                     sr,
  output logic                    out_valid,
  output logic [4*OUT_W-1:0]      quat
);

  localparam int SH = 60 - FRACTION_BITS;
  typedef logic signed [67:0] p_t;

  // Stage A: yaw times pitch, full products.
  p_t   a_ww_r, a_xx_r, a_yy_r, a_zz_r;
  cw_t  a_cr_r, a_sr_r;
  // Stage B: rounded to 30 fraction bits.
  cw_t  b_w_r, b_x_r, b_y_r, b_z_r, b_cr_r, b_sr_r;
  // Stage C: second products.
  p_t   c_p_r [8];
  // Stage D: sums.
  p_t   d_s_r [4];
  logic [4*OUT_W-1:0] e_q_r;
  logic [4:0] v_r;

  function automatic cw_t rnd30(input p_t p);
    p_t t;
    t = (p + (p_t'(1) <<< 29)) >>> 30;
    return t[CW-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] fin(input p_t p);
    p_t t;
    p_t one;
    one = p_t'(1) <<< FRACTION_BITS;
    t = (p + (p_t'(1) <<< (SH - 1))) >>> SH;
    if (t > one) t = one;
    if (t < -one) t = -one;
    return t[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_ww_r <= p_t'(cy) * p_t'(cp);
      a_xx_r <= p_t'(cy) * p_t'(sp);
      a_yy_r <= p_t'(sy) * p_t'(cp);
      a_zz_r <= p_t'(sy) * p_t'(sp);
      a_cr_r <= cr;
      a_sr_r <= sr;
      b_w_r  <= rnd30(a_ww_r);
      b_x_r  <= -rnd30(a_xx_r);
      b_y_r  <= rnd30(a_yy_r);
      b_z_r  <= rnd30(a_zz_r);
      b_cr_r <= a_cr_r;
      b_sr_r <= a_sr_r;
      c_p_r[0] <= p_t'(b_w_r) * p_t'(b_cr_r);
      c_p_r[1] <= p_t'(b_z_r) * p_t'(b_sr_r);
      c_p_r[2] <= p_t'(b_x_r) * p_t'(b_cr_r);
      c_p_r[3] <= p_t'(b_y_r) * p_t'(b_sr_r);
      c_p_r[4] <= p_t'(b_y_r) * p_t'(b_cr_r);
      c_p_r[5] <= p_t'(b_x_r) * p_t'(b_sr_r);
      c_p_r[6] <= p_t'(b_z_r) * p_t'(b_cr_r);
      c_p_r[7] <= p_t'(b_w_r) * p_t'(b_sr_r);
      d_s_r[0] <= c_p_r[0] + c_p_r[1];
      d_s_r[1] <= c_p_r[2] - c_p_r[3];
      d_s_r[2] <= c_p_r[4] + c_p_r[5];
      d_s_r[3] <= c_p_r[6] - c_p_r[7];
      e_q_r <= {fin(d_s_r[3]), fin(d_s_r[2]), fin(d_s_r[1]), fin(d_s_r[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  assign out_valid = v_r[4];
  assign quat      = e_q_r;

endmodule

[hdl/euler_to_quaternion_core.sv]
// Euler angles to unit quaternion. Each input transaction carries yaw, pitch
// and roll as signed binary angles (half the angle range stands for pi); the
// result transaction carries w, x, y, z of qyaw*qpitch*qroll in Q1.14,
// clamped to plus or minus one. The block is fully pipelined: one
// transaction is accepted every cycle while the pipe is not stalled. Each
// passes three parallel 32-stage CORDIC pipes, the product stages with
// rounding and sums, and the output register. The whole pipe stalls only
// while the output register holds a result that is not taken.
module euler_to_quaternion_core
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // yaw_angle, pitch_angle, roll_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  logic en, cv_y, cv_p, cv_r, pv;
  cw_t  cy, sy, cp, sp, cr, sr;
  logic [4*OUT_W-1:0] quat;
  logic [63:0] out_r;
  logic        out_v_r;

  // Pipe advances whenever the output register is empty or being drained.
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle(in_tdata[ANGLE_BITS-1:0]), .out_valid(cv_y), .cos_out(cy), .sin_out(sy));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle(in_tdata[16+ANGLE_BITS-1:16]), .out_valid(cv_p), .cos_out(cp), .sin_out(sp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle(in_tdata[32+ANGLE_BITS-1:32]), .out_valid(cv_r), .cos_out(cr), .sin_out(sr));

  e2q_product #(.FRACTION_BITS(FRACTION_BITS)) u_prod (
    .clk, .rst_n, .en, .in_valid(cv_y),
    .cy, .sy, .cp, .sp, .cr, .sr, .out_valid(pv), .quat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= quat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

`ifndef ASSERT_OFF
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_y == cv_p) && (cv_p == cv_r)) else $error("CORDIC lanes out of step");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |-> !in_tready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_r)) else $error("result lost");
`endif

endmodule
